/* src/bpi_pkg.sv */
// Package for the band power integrator: constants, beat types and the root table.
package bpi_pkg;

  localparam int MAX_ROWS  = 1024;
  localparam int MAX_COLS  = 16;
  localparam int ROW_W     = 10;
  localparam int COL_W     = 4;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int FREQ_W    = 33;
  localparam int ROOT_BITS = 20;
  localparam int LOG_BITS  = 24;
  localparam int CFG_W     = 14;

  localparam logic [23:0] EXP_SCALE = 24'd14267573;
  localparam logic [28:0] LOG_SCALE = 29'd315652829;

  localparam logic [10:0] ROWS_RESET = 11'd1024;
  localparam logic [4:0]  COLS_RESET = 5'd16;
  localparam logic [13:0] RBW_RESET  = 14'd5708;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_RBW  = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SAME_ROW = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  typedef struct packed {
    logic                    func;
    logic [ROW_W-1:0]        row_index;
    logic [COL_W-1:0]        col_index;
    logic [FREQ_W-1:0]       row_freq_hz;
    logic signed [15:0]      power_cdb;
    logic [FREQ_W-1:0]       band_low_hz;
    logic [FREQ_W-1:0]       band_high_hz;
  } in_beat_t;

  typedef struct packed {
    logic [COL_W-1:0]        out_col;
    logic signed [15:0]      band_power_cdb;
    logic [1:0]              status;
    logic                    last;
  } out_beat_t;

  typedef logic [ROOT_BITS-1:0][31:0] root_tab_t;

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] xx;
    r  = 64'd0;
    xx = x;
    for (int i = 0; i < 32; i++) begin
      b = 64'd1 << (62 - 2 * i);
      if (xx >= r + b) begin
        xx = xx - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] v;
    v    = isqrt64(64'd2 << 60);
    t[0] = v[31:0];
    for (int k = 1; k < ROOT_BITS; k++) begin
      v    = isqrt64(v << 30);
      t[k] = v[31:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

endpackage

/* src/band_power_integrator_core.sv */
// Top level of the band power integrator: table memories and query sequencer.
//
// Input channel: a beat is taken at a rising edge with start high and busy low.
//   A load beat (func 0) writes one frequency entry and one power entry;
//   busy stays low and the next beat may follow at once.
//   A query beat (func 1) raises busy until its last result is sent.
// Result channel: out_valid is high for one cycle per result; the receiver
//   takes every result and cannot stall. Results of a query come column by
//   column, the final one marked by last.
// Config port: cfg_we, cfg_index, cfg_data write a register.
// Query sequence: each edge walk visits rows one by one, with a freq memory
//   read and a compare for each row. Per column, a setup step, then each
//   trapezoid interval takes a range check and the reads of both rows, two
//   exponent passes through the shared root multiplier, and the partial
//   products. The log takes a zero check, normalize steps, squaring steps, a
//   multiply and a final rounding step. An error query takes a setup and a raw
//   read per column, only the setup when the lower edge is outside the table.
// Reset: config registers return to their defaults, the sequencer goes idle.
//   The memories are not cleared; entries must be loaded before a query.
module band_power_integrator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bpi_pkg::in_beat_t            in_data,
  output logic                         out_valid,
  output bpi_pkg::out_beat_t           out_data,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bpi_pkg::CFG_W-1:0]    cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LRD   = 5'd1;
  localparam logic [4:0] S_LCMP  = 5'd2;
  localparam logic [4:0] S_COL   = 5'd3;
  localparam logic [4:0] S_RAW   = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;
  localparam logic [4:0] S_RDA   = 5'd6;
  localparam logic [4:0] S_RDB   = 5'd7;
  localparam logic [4:0] S_LATB  = 5'd8;
  localparam logic [4:0] S_EXP   = 5'd9;
  localparam logic [4:0] S_ROOT  = 5'd10;
  localparam logic [4:0] S_SHIFT = 5'd11;
  localparam logic [4:0] S_MUL0  = 5'd12;
  localparam logic [4:0] S_MUL1  = 5'd13;
  localparam logic [4:0] S_MUL2  = 5'd14;
  localparam logic [4:0] S_MUL3  = 5'd15;
  localparam logic [4:0] S_LOGZ  = 5'd16;
  localparam logic [4:0] S_NORM  = 5'd17;
  localparam logic [4:0] S_SQ    = 5'd18;
  localparam logic [4:0] S_LMUL  = 5'd19;
  localparam logic [4:0] S_LFIN  = 5'd20;

  logic [bpi_pkg::FREQ_W-1:0] freq_mem [bpi_pkg::MAX_ROWS];
  logic [15:0]                pow_mem  [bpi_pkg::MAX_ROWS * bpi_pkg::MAX_COLS];
  logic [bpi_pkg::FREQ_W-1:0] freq_q_r;
  logic [15:0]                pow_q_r;
  logic [bpi_pkg::ROW_W-1:0]  f_raddr;
  logic [bpi_pkg::ADDR_W-1:0] p_raddr;
  logic                       load_we;

  logic [10:0] rows_r;
  logic [4:0]  cols_r;
  logic [13:0] rbw_r;
  logic [10:0] rows_eff;
  logic [4:0]  cols_eff;

  logic [4:0]                 state_r, state_nxt;
  logic [bpi_pkg::FREQ_W-1:0] lo_hz_r, lo_hz_nxt, hi_hz_r, hi_hz_nxt;
  logic [bpi_pkg::ROW_W-1:0]  idx_r, idx_nxt;
  logic                       edge_r, edge_nxt, first_r, first_nxt, up_r, up_nxt;
  logic [bpi_pkg::ROW_W-1:0]  p1_r, p1_nxt, p2_r, p2_nxt;
  logic                       p1ok_r, p1ok_nxt;
  logic [1:0]                 status_r, status_nxt;
  logic [bpi_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [bpi_pkg::ROW_W-1:0]  j_r, j_nxt;
  logic [15:0]                pa_r, pa_nxt, pb_r, pb_nxt;
  logic [bpi_pkg::FREQ_W-1:0] f0_r, f0_nxt, df_r, df_nxt;
  logic                       sel_r, sel_nxt;
  logic [40:0]                u_r, u_nxt;
  logic [31:0]                m_r, m_nxt;
  logic [4:0]                 k_r, k_nxt;
  logic [63:0]                lina_r, lina_nxt, linb_r, linb_nxt;
  logic [63:0]                prod_r, prod_nxt;
  logic [127:0]               acc_r, acc_nxt;
  logic [6:0]                 z_r, z_nxt;
  logic [23:0]                frac_r, frac_nxt;
  logic signed [61:0]         lprod_r, lprod_nxt;
  logic                       out_valid_r, out_valid_nxt;
  bpi_pkg::out_beat_t         out_data_r, out_data_nxt;

  logic                       emit;
  logic signed [15:0]         emit_val;
  logic [bpi_pkg::FREQ_W-1:0] x_hz;
  logic                       loc_done, loc_ok;
  logic [10:0]                idx_inc;
  logic signed [17:0]         d_s;
  logic signed [43:0]         t_s;
  logic [63:0]                root_p;
  logic [63:0]                avg;
  logic [95:0]                wide;
  logic [63:0]                lin_val;
  logic [8:0]                 n_int;
  logic [8:0]                 sh;
  logic [63:0]                sq;
  logic [7:0]                 e_m32;
  logic signed [31:0]         l_s;
  logic signed [61:0]         q_full;
  logic signed [17:0]         q_s;

  assign rows_eff = (rows_r < 11'd2) ? 11'd2 :
                    ((rows_r > 11'(bpi_pkg::MAX_ROWS)) ? 11'(bpi_pkg::MAX_ROWS) : rows_r);
  assign cols_eff = (cols_r == 5'd0) ? 5'd1 :
                    ((cols_r > 5'(bpi_pkg::MAX_COLS)) ? 5'(bpi_pkg::MAX_COLS) : cols_r);

  assign load_we = start && !busy && (in_data.func == bpi_pkg::FUNC_LOAD);

  always_ff @(posedge clk) begin
    if (load_we) begin
      freq_mem[in_data.row_index] <= in_data.row_freq_hz;
    end
    freq_q_r <= freq_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      pow_mem[{in_data.row_index, in_data.col_index}] <= in_data.power_cdb;
    end
    pow_q_r <= pow_mem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= bpi_pkg::ROWS_RESET;
      cols_r <= bpi_pkg::COLS_RESET;
      rbw_r  <= bpi_pkg::RBW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bpi_pkg::CFG_ROWS: rows_r <= cfg_data[10:0];
        bpi_pkg::CFG_COLS: cols_r <= cfg_data[4:0];
        bpi_pkg::CFG_RBW:  rbw_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    f_raddr = idx_r;
    p_raddr = {p1_r, col_r};
    unique case (state_r)
      S_RDA:   begin f_raddr = j_r;        p_raddr = {j_r, col_r}; end
      S_RDB:   begin f_raddr = j_r + 1'b1; p_raddr = {j_r + 1'b1, col_r}; end
      default: ;
    endcase
  end

  always_comb begin
    x_hz    = edge_r ? hi_hz_r : lo_hz_r;
    idx_inc = {1'b0, idx_r} + 11'd1;
    d_s     = 18'(signed'(sel_r ? pb_r : pa_r)) - signed'({4'd0, rbw_r});
    t_s     = 44'(d_s) * signed'({20'd0, bpi_pkg::EXP_SCALE});
    root_p  = m_r * bpi_pkg::ROOT_TAB[k_r];
    n_int   = u_r[40:32];
    wide    = 96'd0;
    lin_val = 64'd0;
    if (n_int >= 9'd254) begin
      sh   = n_int - 9'd254;
      wide = {64'd0, m_r} << sh[6:0];
      if (sh >= 9'd63 || wide[95:64] != 32'd0) lin_val = '1;
      else lin_val = wide[63:0];
    end else begin
      sh = 9'd254 - n_int;
      if (sh < 9'd64) lin_val = {32'd0, m_r} >> sh[5:0];
    end
    avg    = (lina_r >> 1) + (linb_r >> 1) + {63'd0, lina_r[0] & linb_r[0]};
    sq     = m_r * m_r;
    e_m32  = 8'(7'd127 - z_r) - 8'd32;
    l_s    = signed'({e_m32, frac_r});
    q_full = (lprod_r + 62'sd8796093022208) >>> 44;
    q_s    = q_full[17:0];
  end

  always_comb begin
    state_nxt     = state_r;
    lo_hz_nxt     = lo_hz_r;
    hi_hz_nxt     = hi_hz_r;
    idx_nxt       = idx_r;
    edge_nxt      = edge_r;
    first_nxt     = first_r;
    up_nxt        = up_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    p1ok_nxt      = p1ok_r;
    status_nxt    = status_r;
    col_nxt       = col_r;
    j_nxt         = j_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    f0_nxt        = f0_r;
    df_nxt        = df_r;
    sel_nxt       = sel_r;
    u_nxt         = u_r;
    m_nxt         = m_r;
    k_nxt         = k_r;
    lina_nxt      = lina_r;
    linb_nxt      = linb_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    z_nxt         = z_r;
    frac_nxt      = frac_r;
    lprod_nxt     = lprod_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    emit          = 1'b0;
    emit_val      = 16'sd0;
    loc_done      = 1'b0;
    loc_ok        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start && in_data.func == bpi_pkg::FUNC_QUERY) begin
          lo_hz_nxt = in_data.band_low_hz;
          hi_hz_nxt = in_data.band_high_hz;
          idx_nxt   = rows_eff[10:1];
          edge_nxt  = 1'b0;
          first_nxt = 1'b1;
          state_nxt = S_LRD;
        end
      end
      S_LRD: state_nxt = S_LCMP;
      S_LCMP: begin
        first_nxt = 1'b0;
        if (first_r ? (freq_q_r < x_hz) : up_r) begin
          up_nxt = 1'b1;
          if (x_hz > freq_q_r) begin
            if (idx_inc == rows_eff) loc_done = 1'b1;
            else begin
              idx_nxt   = idx_inc[9:0];
              state_nxt = S_LRD;
            end
          end else begin
            loc_done = 1'b1;
            loc_ok   = 1'b1;
          end
        end else begin
          up_nxt = 1'b0;
          if (x_hz < freq_q_r) begin
            if (idx_r == '0) loc_done = 1'b1;
            else begin
              idx_nxt   = idx_r - 1'b1;
              state_nxt = S_LRD;
            end
          end else begin
            loc_done = 1'b1;
            loc_ok   = 1'b1;
          end
        end
        if (loc_done) begin
          if (!edge_r) begin
            p1_nxt    = idx_r;
            p1ok_nxt  = loc_ok;
            edge_nxt  = 1'b1;
            first_nxt = 1'b1;
            idx_nxt   = rows_eff[10:1];
            state_nxt = S_LRD;
          end else begin
            p2_nxt = idx_r;
            if (!p1ok_r || !loc_ok) status_nxt = bpi_pkg::ST_OUTSIDE;
            else if (p1_r == idx_r) status_nxt = bpi_pkg::ST_SAME_ROW;
            else status_nxt = bpi_pkg::ST_OK;
            col_nxt   = '0;
            state_nxt = S_COL;
          end
        end
      end
      S_COL: begin
        if (status_r != bpi_pkg::ST_OK) begin
          if (p1ok_r) state_nxt = S_RAW;
          else begin
            emit     = 1'b1;
            emit_val = 16'sd0;
          end
        end else begin
          acc_nxt   = '0;
          j_nxt     = p1_r;
          state_nxt = S_CHK;
        end
      end
      S_RAW: begin
        emit     = 1'b1;
        emit_val = signed'(pow_q_r);
      end
      S_CHK: begin
        if (j_r <= p2_r && ({1'b0, j_r} + 11'd1) < rows_eff) state_nxt = S_RDA;
        else state_nxt = S_LOGZ;
      end
      S_RDA: state_nxt = S_RDB;
      S_RDB: begin
        pa_nxt    = pow_q_r;
        f0_nxt    = freq_q_r;
        state_nxt = S_LATB;
      end
      S_LATB: begin
        pb_nxt    = pow_q_r;
        df_nxt    = (freq_q_r >= f0_r) ? freq_q_r - f0_r : '0;
        sel_nxt   = 1'b0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        u_nxt     = 41'(t_s + 44'sd1099511627776);
        m_nxt     = 32'd1 << 30;
        k_nxt     = '0;
        state_nxt = S_ROOT;
      end
      S_ROOT: begin
        if (u_r[5'd31 - k_r]) m_nxt = root_p[61:30];
        k_nxt = k_r + 1'b1;
        if (k_r == 5'(bpi_pkg::ROOT_BITS - 1)) state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (!sel_r) begin
          lina_nxt  = lin_val;
          sel_nxt   = 1'b1;
          state_nxt = S_EXP;
        end else begin
          linb_nxt  = lin_val;
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        prod_nxt  = avg[31:0] * df_r[31:0];
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        acc_nxt   = acc_r + {64'd0, prod_r};
        prod_nxt  = avg[63:32] * df_r[31:0];
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        acc_nxt   = acc_r + {32'd0, prod_r, 32'd0};
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        if (df_r[32]) acc_nxt = acc_r + {32'd0, avg, 32'd0};
        j_nxt     = j_r + 1'b1;
        state_nxt = S_CHK;
      end
      S_LOGZ: begin
        if (acc_r == '0) begin
          emit     = 1'b1;
          emit_val = -16'sd32768;
        end else begin
          z_nxt     = '0;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (acc_r[127]) begin
          m_nxt     = acc_r[127:96];
          k_nxt     = '0;
          frac_nxt  = '0;
          state_nxt = S_SQ;
        end else if (acc_r[127:112] == 16'd0) begin
          acc_nxt = acc_r << 16;
          z_nxt   = z_r + 7'd16;
        end else begin
          acc_nxt = acc_r << 1;
          z_nxt   = z_r + 7'd1;
        end
      end
      S_SQ: begin
        if (sq[63]) begin
          frac_nxt = {frac_r[22:0], 1'b1};
          m_nxt    = sq[63:32];
        end else begin
          frac_nxt = {frac_r[22:0], 1'b0};
          m_nxt    = sq[62:31];
        end
        k_nxt = k_r + 1'b1;
        if (k_r == 5'(bpi_pkg::LOG_BITS - 1)) state_nxt = S_LMUL;
      end
      S_LMUL: begin
        lprod_nxt = 62'(l_s) * 62'(signed'({1'b0, bpi_pkg::LOG_SCALE}));
        state_nxt = S_LFIN;
      end
      S_LFIN: begin
        emit = 1'b1;
        if (q_s < -18'sd32768) emit_val = -16'sd32768;
        else if (q_s > 18'sd32767) emit_val = 16'sd32767;
        else emit_val = q_s[15:0];
      end
      default: state_nxt = S_IDLE;
    endcase

    if (emit) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.out_col        = col_r;
      out_data_nxt.band_power_cdb = emit_val;
      out_data_nxt.status         = status_r;
      out_data_nxt.last           = ({1'b0, col_r} + 5'd1) == cols_eff;
      if (out_data_nxt.last) state_nxt = S_IDLE;
      else begin
        col_nxt   = col_r + 1'b1;
        state_nxt = S_COL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_hz_r    <= lo_hz_nxt;
    hi_hz_r    <= hi_hz_nxt;
    idx_r      <= idx_nxt;
    edge_r     <= edge_nxt;
    first_r    <= first_nxt;
    up_r       <= up_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    p1ok_r     <= p1ok_nxt;
    status_r   <= status_nxt;
    col_r      <= col_nxt;
    j_r        <= j_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    f0_r       <= f0_nxt;
    df_r       <= df_nxt;
    sel_r      <= sel_nxt;
    u_r        <= u_nxt;
    m_r        <= m_nxt;
    k_r        <= k_nxt;
    lina_r     <= lina_nxt;
    linb_r     <= linb_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    z_r        <= z_nxt;
    frac_r     <= frac_nxt;
    lprod_r    <= lprod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.func == bpi_pkg::FUNC_QUERY |=> busy)
    else $error("query beat did not raise busy");
  a_out_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat outside a query");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> !busy)
    else $error("busy after last result");
`endif

endmodule
